FILE: rtl/core/pvc_pkg.sv
package pvc_pkg;

	localparam int DT_WIDTH_DEF = 24;

	localparam int GAIN_W    = 16;
	localparam int TEMP_W    = 16;
	localparam int ERR_ABS_W = 16;
	localparam int VALVE_W   = 15;
	localparam int ACC_W     = 31;
	localparam int PROD_W    = 64;
	localparam int MUL_W     = 32;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd2560;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd721;

	// 100 % in units of 2^-24 %.
	localparam logic [ACC_W-1:0] PCT_FULL = 31'd1677721600;
	localparam logic [VALVE_W-1:0] VALVE_MAX = 15'd25600;

	// A quotient at or above 2^31 always drives the integral to a limit.
	localparam int QUO_W = 31;
	localparam logic [9:0] DIVISOR = 10'd1000;
	localparam logic [PROD_W-1:0] DIV_LIMIT = 64'd2147483648000;

	// The divide by 1000 takes two reciprocal multiplications: first the bits
	// above DIV_SPLIT, then their remainder joined with the bits below.
	localparam int DIV_SPLIT   = 20;
	localparam int QUO_HI_W    = QUO_W - DIV_SPLIT;
	localparam int RECIP_SHIFT = 41;
	localparam logic [MUL_W-1:0] RECIP_1000 = 32'd2199023256;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
	} pvc_gains_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_CHK,
		ST_REM,
		ST_DIV,
		ST_ACC,
		ST_SUM
	} pvc_state_t;

endpackage

FILE: rtl/core/pvc_queue.sv
module pvc_queue import pvc_pkg::*; #(
	parameter int WIDTH = 41
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(QUEUE_DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

endmodule

FILE: rtl/core/pvc_front.sv
module pvc_front import pvc_pkg::*; #(
	parameter int DT_WIDTH = DT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [95:0]                       s_axis_tdata,
	input  logic [1:0]                        s_axis_tuser,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [DT_WIDTH+ERR_ABS_W:0]       q_data
);

	logic [PROD_W-1:0]   prev_time_q;
	logic [PROD_W-1:0]   now_time;
	logic [PROD_W-1:0]   gap;
	logic [DT_WIDTH-1:0] dt;
	logic [TEMP_W:0]     err;
	logic                err_neg;
	logic [TEMP_W:0]     err_mag;
	logic                accept;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign now_time      = s_axis_tdata[63:0];

	always_comb begin
		gap = now_time - prev_time_q;
		if (prev_time_q == '0) begin
			dt = '0;
		end else if (gap[PROD_W-1:DT_WIDTH] != '0) begin
			dt = '1;
		end else begin
			dt = gap[DT_WIDTH-1:0];
		end
		err     = {s_axis_tdata[95], s_axis_tdata[95:80]}
			- {s_axis_tdata[79], s_axis_tdata[79:64]};
		err_neg = err[TEMP_W];
		err_mag = err_neg ? (~err + 1'b1) : err;
	end

	assign q_push = accept && s_axis_tuser[0] && s_axis_tuser[1];
	assign q_data = {dt, err_neg, err_mag[ERR_ABS_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
		end else if (accept) begin
			prev_time_q <= now_time;
		end
	end

endmodule

FILE: rtl/core/pvc_back.sv
module pvc_back import pvc_pkg::*; #(
	parameter int DT_WIDTH = DT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvc_gains_t                    gains,
	input  logic                          q_valid,
	input  logic [DT_WIDTH+ERR_ABS_W:0]   q_data,
	output logic                          q_pop,
	output logic                          out_tvalid,
	input  logic                          out_tready,
	output logic [VALVE_W-1:0]            out_tdata
);

	pvc_state_t state_q;
	pvc_state_t state_d;

	logic [ERR_ABS_W-1:0] err_abs_q;
	logic                 err_neg_q;
	logic [DT_WIDTH-1:0]  dt_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 sat_q;
	logic [QUO_HI_W-1:0]  quo_hi_q;
	logic [9:0]           rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [ACC_W-1:0]     integ_acc_q;
	logic                 out_valid_q;
	logic [VALVE_W-1:0]   out_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              over_limit;
	logic [20:0]       rem_full;
	logic [32:0]       acc_ext;
	logic [32:0]       acc_dn;
	logic [32:0]       acc_up;
	logic [ACC_W-1:0]  acc_new;
	logic [39:0]       p_scaled;
	logic [41:0]       sum_dn;
	logic [41:0]       sum_up;
	logic [ACC_W-1:0]  sum_clamped;
	logic              out_free;

	assign out_free   = !out_valid_q || out_tready;
	assign over_limit = (prod_q >= DIV_LIMIT);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_CHK;
			ST_CHK: begin
				state_d = over_limit ? ST_ACC : ST_REM;
			end
			ST_REM: state_d = ST_DIV;
			ST_DIV: state_d = ST_ACC;
			ST_ACC: state_d = ST_SUM;
			ST_SUM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = MUL_W'(err_abs_q);
				mul_b = MUL_W'(gains.integ_gain);
			end
			ST_MUL2: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = MUL_W'(dt_q);
			end
			ST_CHK: begin
				mul_a = MUL_W'(prod_q[40:DIV_SPLIT]);
				mul_b = RECIP_1000;
			end
			ST_DIV: begin
				mul_a = MUL_W'({rem_q, prod_q[DIV_SPLIT-1:0]});
				mul_b = RECIP_1000;
			end
			default: begin
				mul_a = MUL_W'(err_abs_q);
				mul_b = MUL_W'(gains.prop_gain);
			end
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_comb begin
		rem_full = prod_q[40:DIV_SPLIT] - (21'(quo_hi_q) * 21'(DIVISOR));

		acc_ext = {2'b00, integ_acc_q};
		acc_dn  = acc_ext - {2'b00, quo_q};
		acc_up  = acc_ext + {2'b00, quo_q};
		if (err_neg_q) begin
			acc_new = (sat_q || acc_dn[32]) ? '0 : acc_dn[ACC_W-1:0];
		end else begin
			acc_new = (sat_q || (acc_up > {2'b00, PCT_FULL})) ? PCT_FULL
				: acc_up[ACC_W-1:0];
		end

		p_scaled = {prod_q[MUL_W-1:0], 8'h00};
		sum_dn   = {11'd0, integ_acc_q} - {2'b00, p_scaled};
		sum_up   = {11'd0, integ_acc_q} + {2'b00, p_scaled};
		if (err_neg_q) begin
			sum_clamped = sum_dn[41] ? '0 : sum_dn[ACC_W-1:0];
		end else begin
			sum_clamped = (sum_up > {11'd0, PCT_FULL}) ? PCT_FULL
				: sum_up[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				integ_acc_q <= acc_new;
			end
			if (state_q == ST_SUM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_abs_q <= q_data[ERR_ABS_W-1:0];
				err_neg_q <= q_data[ERR_ABS_W];
				dt_q      <= q_data[ERR_ABS_W+1 +: DT_WIDTH];
			end
			ST_MUL1, ST_MUL2, ST_ACC: begin
				prod_q <= mul_p;
			end
			ST_CHK: begin
				sat_q    <= over_limit;
				quo_hi_q <= mul_p[RECIP_SHIFT +: QUO_HI_W];
			end
			ST_REM: begin
				rem_q <= rem_full[9:0];
			end
			ST_DIV: begin
				quo_q <= {quo_hi_q, mul_p[RECIP_SHIFT +: DIV_SPLIT]};
			end
			ST_SUM: begin
				if (out_free) begin
					out_q <= sum_clamped[ACC_W-1:16];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_q;

	a_acc_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC) |=> $stable(integ_acc_q))
		else $error("integral changed outside its update step");

	a_valve_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q <= VALVE_MAX))
		else $error("valve drive above full scale");

	a_saturate_skips_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && over_limit) |=> (state_q == ST_ACC && sat_q))
		else $error("oversized step did not saturate");

endmodule

FILE: rtl/core/pi_valve_controller_top.sv
// Channel  Signals                         Payload (lowest bit first)
// s_axis   tvalid tready tdata[95:0] tuser now_time_ms, room_temp, target_temp | temp_ok, target_ok
// m_axis   tvalid tready tdata[15:0]       valve_percent, one zero pad bit
// cfg      valid ready index[7:0] data     register index, 16-bit value
//
// An item with both readings valid passes the back end in order: dequeue, two products
// on the shared 32x32 multiplier, a range check with the high quotient digit of the
// divide by 1000, its remainder, the low digit, integral update with the proportional
// product, sum. A step large enough to saturate the integral skips the divide.
// The two-entry queue takes new items while the back end works; s_axis stalls
// only when it is full. Reset clears timestamp and integral and loads default gains.
module pi_valve_controller_top import pvc_pkg::*; #(
	parameter int DT_WIDTH = DT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [95:0]          s_axis_tdata,  // now_time_ms, room_temp, target_temp
	input  logic [1:0]           s_axis_tuser,  // temp_ok, target_ok
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [15:0]          m_axis_tdata,  // valve_percent, zero pad
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	localparam int ITEM_W = DT_WIDTH + ERR_ABS_W + 1;

	pvc_gains_t         gains_q;
	logic               q_full;
	logic               q_push;
	logic [ITEM_W-1:0]  q_wdata;
	logic               q_valid;
	logic               q_pop;
	logic [ITEM_W-1:0]  q_rdata;
	logic [VALVE_W-1:0] valve;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain  <= PROP_GAIN_RST;
			gains_q.integ_gain <= INTEG_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_PROP_GAIN) begin
				gains_q.prop_gain <= cfg_data;
			end else if (cfg_index == REG_INTEG_GAIN) begin
				gains_q.integ_gain <= cfg_data;
			end
		end
	end

	pvc_front #(
		.DT_WIDTH(DT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	pvc_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_data (q_rdata)
	);

	pvc_back #(
		.DT_WIDTH(DT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.out_tdata (valve)
	);

	assign m_axis_tdata = {1'b0, valve};

endmodule
